// ----- hw/rtl/twt_pkg.sv -----
// ----------------------------------------------------------------------------
// twt_pkg: timer wheel table shared types
// Transfer structs, operation and status codes, expiry limits.
// ----------------------------------------------------------------------------
package twt_pkg;

    localparam int MAX_OUT = 16;                  // most expiries reported per tick
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_REFRESH = 3'd1;
    localparam logic [2:0] OP_CANCEL  = 3'd2;
    localparam logic [2:0] OP_QUERY   = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_FULL        = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND   = 2'd3;

    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] timer_id;
        logic [7:0]  timeout_ticks;
    } twt_cmd_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic        present;
        logic [31:0] expired_id;
        logic        fired;
        logic        last;
    } twt_rsp_t;

endpackage

// ----- hw/rtl/timer_wheel_table_unit.sv -----
// ----------------------------------------------------------------------------
// timer_wheel_table_unit: table of id-keyed timers driven by tick transfers
// Sequential scan engine over a one-read, one-write entry RAM plus valid flops.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries add, refresh, cancel,
//   query and tick operations. rsp channel (rsp_valid / rsp_stall / rsp)
//   returns one reply per non-tick command and one expiry report per freed timer on
//   a tick (ascending slot order, last set on the final one, no transfer
//   at all for a tick with nothing due).
// Operation:
//   - add/refresh/cancel/query scan all entries, each with a RAM read and a
//     compare, then one write step and one reply step. Unused op codes skip
//     the scan and go straight to the reply.
//   - a tick decrements every valid entry, then walks the due list: skipped
//     entries are passed over, each reported expiry takes a read and a report.
//   The engine returns to idle after each item before the next transfer is
//   taken, so a new command is not accepted while one is in progress.
//   cmd_stall stays high from acceptance until the item is done.
// Reset: all entries invalid, rsp_valid low, ready for a transfer at once.
//   Entry RAM contents are not cleared; valid flops gate every read.
// rsp_stall: the result register holds; the engine waits when it needs to
//   load a new result while the register is still full.
// ----------------------------------------------------------------------------
module timer_wheel_table_unit #(
    parameter int WHEEL_SLOTS = 64,
    parameter int NUM_TIMERS  = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  twt_pkg::twt_cmd_t cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output twt_pkg::twt_rsp_t rsp
);
    import twt_pkg::*;

    localparam int TW = $clog2(WHEEL_SLOTS + 1);             // timeout width
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);

    typedef struct packed {
        logic [31:0]   id;
        logic [TW-1:0] timeout;
        logic [TW-1:0] remaining;
        logic          cancelled;
    } entry_t;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CRD  = 9'b000000010,   // command scan: read
        S_CEV  = 9'b000000100,   // command scan: compare
        S_CWR  = 9'b000001000,   // command update
        S_CREP = 9'b000010000,   // command reply
        S_TRD  = 9'b000100000,   // tick scan: read
        S_TEV  = 9'b001000000,   // tick scan: decrement
        S_ERD  = 9'b010000000,   // expiry walk: read
        S_EEV  = 9'b100000000    // expiry walk: report
    } state_t;

    // entry RAM
    entry_t        mem [NUM_TIMERS];
    entry_t        rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;

    state_t          state_reg, state_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [2:0]      op_reg;
    logic [31:0]     id_reg;
    logic [7:0]      to_reg;
    logic            hit_found_reg, hit_found_next;
    logic [IW-1:0]   hit_idx_reg, hit_idx_next;
    entry_t          hit_entry_reg, hit_entry_next;
    logic            free_found_reg, free_found_next;
    logic [IW-1:0]   free_idx_reg, free_idx_next;
    logic [1:0]      status_reg, status_next;
    logic [NUM_TIMERS-1:0] valid_reg, valid_next;
    logic [NUM_TIMERS-1:0] due_reg, due_next;
    logic [CNT_W-1:0] due_cnt_reg, due_cnt_next;
    logic [CNT_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic            out_valid_reg, out_valid_next;
    twt_rsp_t        out_reg, out_next;

    logic            accept;
    logic            out_free;
    logic            load_out;
    logic [IW-1:0]   cur;
    logic            last_idx;
    logic            bad_to;
    logic [TW-1:0]   rem_dec;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign cur       = idx_reg[IW-1:0];
    assign last_idx  = (idx_reg == CW'(NUM_TIMERS - 1));
    assign bad_to    = (to_reg == 8'd0) || ({1'b0, to_reg} > 9'(WHEEL_SLOTS));
    assign rem_dec   = (rd_data_reg.remaining != '0) ?
                       (rd_data_reg.remaining - TW'(1)) : rd_data_reg.remaining;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_entry_next  = hit_entry_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        status_next     = status_reg;
        valid_next      = valid_reg;
        due_next        = due_reg;
        due_cnt_next    = due_cnt_reg;
        emit_cnt_next   = emit_cnt_reg;
        out_next        = out_reg;
        load_out        = 1'b0;
        rd_addr         = cur;
        wr_en           = 1'b0;
        wr_addr         = cur;
        wr_data         = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next        = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    status_next     = ST_OK;
                    due_next        = '0;
                    due_cnt_next    = '0;
                    emit_cnt_next   = '0;
                    if (cmd.op == OP_TICK)
                        state_next = S_TRD;
                    else if (cmd.op > OP_TICK)
                        state_next = S_CREP;       // unused code: plain ok reply
                    else
                        state_next = S_CRD;
                end
            end
            S_CRD:
            begin
                state_next = S_CEV;
            end
            S_CEV:
            begin
                if (valid_reg[cur] && (rd_data_reg.id == id_reg) && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = cur;
                    hit_entry_next = rd_data_reg;
                end
                if (!valid_reg[cur] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cur;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = last_idx ? S_CWR : S_CRD;
            end
            S_CWR:
            begin
                state_next = S_CREP;
                case (op_reg)
                    OP_ADD:
                    begin
                        wr_data.id        = id_reg;
                        wr_data.timeout   = to_reg[TW-1:0];
                        wr_data.remaining = to_reg[TW-1:0];
                        wr_data.cancelled = 1'b0;
                        if (bad_to)
                            status_next = ST_BAD_TIMEOUT;
                        else if (hit_found_reg || free_found_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = hit_found_reg ? hit_idx_reg : free_idx_reg;
                            valid_next[wr_addr] = 1'b1;
                        end
                        else
                            status_next = ST_FULL;
                    end
                    OP_REFRESH, OP_CANCEL, OP_QUERY:
                    begin
                        wr_data = hit_entry_reg;
                        wr_addr = hit_idx_reg;
                        if (!hit_found_reg)
                            status_next = ST_NOT_FOUND;
                        else if (op_reg == OP_REFRESH)
                        begin
                            wr_en             = 1'b1;
                            wr_data.remaining = hit_entry_reg.timeout;
                        end
                        else if (op_reg == OP_CANCEL)
                        begin
                            wr_en             = 1'b1;
                            wr_data.cancelled = 1'b1;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_CREP:
            begin
                if (out_free)
                begin
                    load_out           = 1'b1;
                    out_next.kind       = KIND_REPLY;
                    out_next.status     = status_reg;
                    out_next.present    = hit_found_reg;
                    out_next.expired_id = '0;
                    out_next.fired      = 1'b0;
                    out_next.last       = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            S_TRD:
            begin
                state_next = S_TEV;
            end
            S_TEV:
            begin
                if (valid_reg[cur])
                begin
                    wr_en             = 1'b1;
                    wr_data.remaining = rem_dec;
                    if ((rem_dec == '0) && (due_cnt_reg < CNT_W'(MAX_OUT)))
                    begin
                        due_next[cur] = 1'b1;
                        due_cnt_next  = due_cnt_reg + CNT_W'(1);
                    end
                end
                idx_next = idx_reg + CW'(1);
                if (!last_idx)
                    state_next = S_TRD;
                else if (due_cnt_next == '0)
                    state_next = S_IDLE;           // nothing due: no transfer
                else
                begin
                    idx_next   = '0;
                    state_next = S_ERD;
                end
            end
            S_ERD:
            begin
                if (due_reg[cur])
                    state_next = S_EEV;
                else
                    idx_next = idx_reg + CW'(1);
            end
            S_EEV:
            begin
                if (out_free)
                begin
                    load_out            = 1'b1;
                    out_next.kind       = KIND_EXPIRY;
                    out_next.status     = ST_OK;
                    out_next.present    = 1'b0;
                    out_next.expired_id = rd_data_reg.id;
                    out_next.fired      = !rd_data_reg.cancelled;
                    out_next.last       = ((emit_cnt_reg + CNT_W'(1)) == due_cnt_reg);
                    valid_next[cur]     = 1'b0;
                    due_next[cur]       = 1'b0;
                    emit_cnt_next       = emit_cnt_reg + CNT_W'(1);
                    idx_next            = idx_reg + CW'(1);
                    state_next          = out_next.last ? S_IDLE : S_ERD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (!rsp_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // entry RAM: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            status_reg     <= ST_OK;
            valid_reg      <= '0;
            due_reg        <= '0;
            due_cnt_reg    <= '0;
            emit_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            status_reg     <= status_next;
            valid_reg      <= valid_next;
            due_reg        <= due_next;
            due_cnt_reg    <= due_cnt_next;
            emit_cnt_reg   <= emit_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= cmd.op;
            id_reg <= cmd.timer_id;
            to_reg <= cmd.timeout_ticks;
        end
        hit_idx_reg   <= hit_idx_next;
        hit_entry_reg <= hit_entry_next;
        free_idx_reg  <= free_idx_next;
        out_reg       <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // ---------------------------------------------------------------- checks
    a_reply_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind == KIND_REPLY) |-> rsp.last)
        else $error("command reply without last");

    a_due_bound: assert property (@(posedge clk) disable iff (!rst_n)
        due_cnt_reg <= CNT_W'(MAX_OUT))
        else $error("due count above expiry limit");

    a_due_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERD || state_reg == S_EEV) |->
        ($countones(due_reg) == int'(due_cnt_reg - emit_cnt_reg)))
        else $error("due flags out of step with counters");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.op != OP_TICK) |=> cmd_stall)
        else $error("engine ready right after a command");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EEV) |-> (emit_cnt_reg < due_cnt_reg))
        else $error("expiry walk past due count");

endmodule
